### rtl/rcpc_pkg.sv
// Shared types, register codes and constants for the RC pulse channel conditioner.
`timescale 1ns / 1ps

package rcpc_pkg;

	localparam int WIDTH_BITS = 13;
	localparam int EPS_BITS   = 16;
	localparam int CMD_BITS   = 16;
	localparam int DIV_STEPS  = 16;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// pulses longer than this count as a timeout
	localparam logic [WIDTH_BITS-1:0] WIDTH_TIMEOUT = 13'd5000;

	localparam logic [2:0] REG_STEER_MIN    = 3'd0;
	localparam logic [2:0] REG_STEER_MAX    = 3'd1;
	localparam logic [2:0] REG_THROTTLE_MIN = 3'd2;
	localparam logic [2:0] REG_THROTTLE_MAX = 3'd3;
	localparam logic [2:0] REG_SWITCH_THR   = 3'd4;
	localparam logic [2:0] REG_EPSILON      = 3'd5;

	localparam logic [WIDTH_BITS-1:0] RST_NOMINAL_MIN = 13'd1000;
	localparam logic [WIDTH_BITS-1:0] RST_NOMINAL_MAX = 13'd2000;
	localparam logic [WIDTH_BITS-1:0] RST_SWITCH_THR  = 13'd1500;
	localparam logic [EPS_BITS-1:0]   RST_EPSILON     = 16'd3277;

	typedef logic [WIDTH_BITS-1:0] width_t;
	typedef logic signed [CMD_BITS-1:0] cmd_t;

	typedef struct packed {
		width_t              steer_min;
		width_t              steer_max;
		width_t              throttle_min;
		width_t              throttle_max;
		width_t              switch_thr;
		logic [EPS_BITS-1:0] epsilon;
	} cfg_t;

	typedef struct packed {
		logic       en;
		logic [2:0] idx;
		width_t     data;
	} cfg_wr_t;

	typedef struct packed {
		width_t calib;
		width_t arm;
		width_t throttle;
		width_t steer;
	} frame_t;

	typedef struct packed {
		cmd_t throttle_cmd;
		cmd_t steer_cmd;
		logic is_armed;
		logic link_up;
	} res_t;

	typedef struct packed {
		logic                   start;
		logic [WIDTH_BITS:0]    rem;
		logic [CMD_BITS-1:0]    lo;
		logic [WIDTH_BITS:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [CMD_BITS-1:0] quot;
	} div_rsp_t;

endpackage

### rtl/rcpc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rcpc_div import rcpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [WIDTH_BITS:0]   rem_q;
	logic [WIDTH_BITS:0]   div_q;
	logic [CMD_BITS-1:0]   sh_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [WIDTH_BITS+1:0] trial;
	logic [WIDTH_BITS+1:0] trial_sub;
	logic                  qbit;

	// remainder shifted left with the next dividend bit
	always_comb begin
		trial     = {rem_q, sh_q[CMD_BITS-1]};
		qbit      = trial >= {1'b0, div_q};
		trial_sub = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend low bits shift out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			div_q <= req.divisor;
			sh_q  <= req.lo;
		end else if (busy_q) begin
			rem_q <= qbit ? trial_sub[WIDTH_BITS:0] : trial[WIDTH_BITS:0];
			sh_q  <= {sh_q[CMD_BITS-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");
`endif

endmodule

### rtl/rcpc_core.sv
// Frame sequencer: glitch filter, link and arm logic, calibration and command mapping.
`timescale 1ns / 1ps

module rcpc_core import rcpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  cfg_wr_t  cfg_wr,
	input  logic     in_valid,
	output logic     in_ready,
	input  frame_t   in_frame,
	output logic     out_valid,
	input  logic     out_ready,
	output res_t     out_res,
	output div_req_t div_req,
	input  div_rsp_t div_rsp
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_FILT = 6'b000010,
		ST_LINK = 6'b000100,
		ST_MAP  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	localparam cmd_t CMD_ZERO = 16'sh0000;
	localparam cmd_t CMD_LOW  = 16'sh8000;
	localparam cmd_t CMD_HIGH = 16'sh7FFF;

	function automatic width_t clamp_width(input width_t w);
		return (w > WIDTH_TIMEOUT) ? '0 : w;
	endfunction

	// returns {new max, new min}
	function automatic logic [2*WIDTH_BITS-1:0] calib_limits(input width_t v,
			input width_t lmin, input width_t lmax, input width_t nmin, input width_t nmax);
		logic [15:0] v4;
		logic [15:0] lo_bound;
		logic [15:0] hi_bound;
		width_t      new_min;
		width_t      new_max;
		v4       = {1'b0, v, 2'b00};
		lo_bound = {3'b000, nmin} + {2'b00, nmin, 1'b0} + {3'b000, nmax};
		hi_bound = {3'b000, nmin} + {3'b000, nmax} + {2'b00, nmax, 1'b0};
		new_min  = lmin;
		new_max  = lmax;
		if (v4 < lo_bound && (v < lmin || lmin == nmin))
			new_min = v;
		if (v4 > hi_bound && (v > lmax || lmax == nmax))
			new_max = v;
		return {new_max, new_min};
	endfunction

	state_t state_q;
	logic [1:0] ch_q;
	logic       map_ch_q;
	width_t     in_q  [4];
	width_t     raw_q [4];
	width_t     acc_q [4];
	logic       linked_q;
	logic       armed_q;
	width_t     st_min_q, st_max_q, th_min_q, th_max_q;
	cmd_t       st_cmd_q, th_cmd_q;
	logic       m_valid_q;
	res_t       m_res_q;

	// filter datapath
	width_t      f_w, f_prev, f_diff;
	logic        f_reject;
	width_t      mul_b;
	logic [28:0] prod;

	// link, arm and calibration
	logic                    link_nx, armed_nx, cal_en;
	logic [2*WIDTH_BITS-1:0] st_lim_nx, th_lim_nx;

	// mapping datapath
	width_t             m_v, m_min, m_max, den;
	logic signed [13:0] num_r, den_r, num;
	logic signed [15:0] num16, tdiff;
	logic [14:0]        tabs;
	logic               deadband, num_neg, ovf;
	logic               cmd_wr, div_start, out_load;
	cmd_t               cmd_val;

	always_comb begin
		f_w      = in_q[ch_q];
		f_prev   = raw_q[ch_q];
		f_diff   = (f_prev > f_w) ? f_prev - f_w : f_w - f_prev;
		mul_b    = (state_q == ST_FILT) ? f_prev : den;
		prod     = 29'(cfg.epsilon) * 29'(mul_b);
		f_reject = {f_diff, 16'h0000} > prod;
	end

	always_comb begin
		link_nx   = linked_q | (acc_q[0] != '0 && acc_q[1] != '0 && acc_q[2] != '0);
		armed_nx  = link_nx ? (acc_q[2] >= cfg.switch_thr) : armed_q;
		cal_en    = link_nx && !armed_nx && (acc_q[3] >= cfg.switch_thr);
		st_lim_nx = calib_limits(acc_q[0], st_min_q, st_max_q, cfg.steer_min, cfg.steer_max);
		th_lim_nx = calib_limits(acc_q[1], th_min_q, th_max_q,
			cfg.throttle_min, cfg.throttle_max);
	end

	always_comb begin
		m_v     = acc_q[{1'b0, map_ch_q}];
		m_min   = map_ch_q ? th_min_q : st_min_q;
		m_max   = map_ch_q ? th_max_q : st_max_q;
		num_r   = $signed({1'b0, m_v}) - $signed({1'b0, m_min});
		den_r   = $signed({1'b0, m_max}) - $signed({1'b0, m_min});
		num     = den_r[13] ? -num_r : num_r;
		den     = den_r[13] ? WIDTH_BITS'(-den_r) : den_r[WIDTH_BITS-1:0];
		num16   = {{2{num[13]}}, num};
		tdiff   = (num16 <<< 1) - $signed({3'b000, den});
		tabs    = tdiff[15] ? 15'(-tdiff) : tdiff[14:0];
		deadband = {tabs, 16'h0000} < {2'b00, prod};
		num_neg = num[13];
		// command saturates high exactly when num >= den
		ovf     = !num_neg && (num[WIDTH_BITS-1:0] >= den);
	end

	always_comb begin
		cmd_wr    = 1'b0;
		cmd_val   = CMD_ZERO;
		div_start = 1'b0;
		if (state_q == ST_MAP) begin
			priority if (!(linked_q && armed_q) || den == '0 || deadband) begin
				cmd_wr = 1'b1;
			end else if (num_neg) begin
				cmd_wr  = 1'b1;
				cmd_val = CMD_LOW;
			end else if (ovf) begin
				cmd_wr  = 1'b1;
				cmd_val = CMD_HIGH;
			end else begin
				div_start = 1'b1;
			end
		end else if (state_q == ST_DIV && div_rsp.done) begin
			cmd_wr  = 1'b1;
			cmd_val = {~div_rsp.quot[CMD_BITS-1], div_rsp.quot[CMD_BITS-2:0]};
		end
	end

	// quotient of (2*num*2^16 + den) / (2*den), with 2*num < 2*den
	assign div_req.start   = div_start;
	assign div_req.rem     = {num[WIDTH_BITS-1:0], 1'b0};
	assign div_req.lo      = {3'b000, den};
	assign div_req.divisor = {den, 1'b0};

	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = m_valid_q;
	assign out_res   = m_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ch_q      <= '0;
			map_ch_q  <= 1'b0;
			linked_q  <= 1'b0;
			armed_q   <= 1'b0;
			m_valid_q <= 1'b0;
			st_min_q  <= RST_NOMINAL_MIN;
			st_max_q  <= RST_NOMINAL_MAX;
			th_min_q  <= RST_NOMINAL_MIN;
			th_max_q  <= RST_NOMINAL_MAX;
			for (int i = 0; i < 4; i++) begin
				raw_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			if (out_load)
				m_valid_q <= 1'b1;
			else if (out_ready)
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ch_q    <= '0;
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					raw_q[ch_q] <= f_w;
					if (!f_reject)
						acc_q[ch_q] <= f_w;
					ch_q <= ch_q + 1'b1;
					if (ch_q == 2'd3)
						state_q <= ST_LINK;
				end
				ST_LINK: begin
					linked_q <= link_nx;
					armed_q  <= armed_nx;
					if (cal_en) begin
						{st_max_q, st_min_q} <= st_lim_nx;
						{th_max_q, th_min_q} <= th_lim_nx;
					end
					map_ch_q <= 1'b0;
					state_q  <= ST_MAP;
				end
				ST_MAP: begin
					if (div_start)
						state_q <= ST_DIV;
					else if (map_ch_q)
						state_q <= ST_OUT;
					else
						map_ch_q <= 1'b1;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (map_ch_q) begin
							state_q <= ST_OUT;
						end else begin
							map_ch_q <= 1'b1;
							state_q  <= ST_MAP;
						end
					end
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			// nominal writes restart the limits from the nominal scale
			if (cfg_wr.en) begin
				if (cfg_wr.idx == REG_STEER_MIN)
					st_min_q <= cfg_wr.data;
				if (cfg_wr.idx == REG_STEER_MAX)
					st_max_q <= cfg_wr.data;
				if (cfg_wr.idx == REG_THROTTLE_MIN)
					th_min_q <= cfg_wr.data;
				if (cfg_wr.idx == REG_THROTTLE_MAX)
					th_max_q <= cfg_wr.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q[0] <= clamp_width(in_frame.steer);
			in_q[1] <= clamp_width(in_frame.throttle);
			in_q[2] <= clamp_width(in_frame.arm);
			in_q[3] <= clamp_width(in_frame.calib);
		end
		if (cmd_wr) begin
			if (map_ch_q)
				th_cmd_q <= cmd_val;
			else
				st_cmd_q <= cmd_val;
		end
		if (out_load) begin
			m_res_q.link_up      <= linked_q;
			m_res_q.is_armed     <= armed_q;
			m_res_q.steer_cmd    <= st_cmd_q;
			m_res_q.throttle_cmd <= th_cmd_q;
		end
	end

`ifndef SYNTHESIS
	a_armed_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> linked_q)
		else $error("armed while the link is down");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider result outside the divide state");

	a_disarmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !(linked_q && armed_q) |=>
			(m_res_q.steer_cmd == CMD_ZERO) && (m_res_q.throttle_cmd == CMD_ZERO))
		else $error("nonzero command while disarmed");
`endif

endmodule

### rtl/rc_pulse_channel_conditioner.sv
// RC pulse channel conditioner top level: APB register file, stream ports, core and divider.
// Sequence: input transfer, a glitch-filter step per channel, link/arm/calibration, then the
// steer and throttle mapping, each through the 16-step bit-serial divider when a division is
// needed, then the output register load. One frame is processed at a time; the next frame is
// taken once the result sits in the output register, which holds while m_tready is low.
// Reset (arst_n low, asynchronous): registers to defaults, limits to nominal, filters cleared.
`timescale 1ns / 1ps

module rc_pulse_channel_conditioner import rcpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // steer_width, throttle_width, arm_width, calib_width
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // link_up, is_armed, steer_cmd, throttle_cmd
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	cfg_wr_t  cfg_wr;
	frame_t   frame;
	res_t     res;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	assign cfg_wr.en   = wr_en;
	assign cfg_wr.idx  = reg_idx;
	assign cfg_wr.data = pwdata[WIDTH_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_min    <= RST_NOMINAL_MIN;
			cfg_q.steer_max    <= RST_NOMINAL_MAX;
			cfg_q.throttle_min <= RST_NOMINAL_MIN;
			cfg_q.throttle_max <= RST_NOMINAL_MAX;
			cfg_q.switch_thr   <= RST_SWITCH_THR;
			cfg_q.epsilon      <= RST_EPSILON;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STEER_MIN:    cfg_q.steer_min    <= pwdata[WIDTH_BITS-1:0];
				REG_STEER_MAX:    cfg_q.steer_max    <= pwdata[WIDTH_BITS-1:0];
				REG_THROTTLE_MIN: cfg_q.throttle_min <= pwdata[WIDTH_BITS-1:0];
				REG_THROTTLE_MAX: cfg_q.throttle_max <= pwdata[WIDTH_BITS-1:0];
				REG_SWITCH_THR:   cfg_q.switch_thr   <= pwdata[WIDTH_BITS-1:0];
				REG_EPSILON:      cfg_q.epsilon      <= pwdata[EPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEER_MIN:    prdata = {19'b0, cfg_q.steer_min};
			REG_STEER_MAX:    prdata = {19'b0, cfg_q.steer_max};
			REG_THROTTLE_MIN: prdata = {19'b0, cfg_q.throttle_min};
			REG_THROTTLE_MAX: prdata = {19'b0, cfg_q.throttle_max};
			REG_SWITCH_THR:   prdata = {19'b0, cfg_q.switch_thr};
			REG_EPSILON:      prdata = {16'b0, cfg_q.epsilon};
			default:          prdata = 32'b0;
		endcase
	end

	assign frame.steer    = s_tdata[12:0];
	assign frame.throttle = s_tdata[25:13];
	assign frame.arm      = s_tdata[38:26];
	assign frame.calib    = s_tdata[51:39];

	assign m_tdata = {6'b0, res.throttle_cmd, res.steer_cmd, res.is_armed, res.link_up};

	rcpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wr    (cfg_wr),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_frame  (frame),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	rcpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### tb/tb_rc_pulse_channel_conditioner.sv
// Self-checking testbench for the RC pulse channel conditioner: directed frames, then random runs.
`timescale 1ns / 1ps

module tb_rc_pulse_channel_conditioner;
	import rcpc_pkg::*;

	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         DRAIN_CYCLES = 60;
	localparam int         PHASE_ITEMS  = 150;
	localparam int         PHASE_COUNT  = 11;
	localparam logic [2:0] REG_SPARE_A  = 3'd6;
	localparam logic [2:0] REG_SPARE_B  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;  // steer_width, throttle_width, arm_width, calib_width
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // link_up, is_armed, steer_cmd, throttle_cmd
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rc_pulse_channel_conditioner DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the conditioner: [channel][0 = min, 1 = max], channel 0 steer, 1 throttle
	width_t      nom_lim [2][2];
	width_t      cur_lim [2][2];
	width_t      switch_on_thr;
	logic [15:0] eps_frac;
	width_t      last_raw [4];
	width_t      held_width [4];
	logic        link_seen;
	logic        armed_seen;

	res_t pending_results [$];

	int chan_pos [4];
	int chan_goal [4];

	bit          idle_en = 1'b1;
	int          send_calm = 0;
	int unsigned cycle_count = 0;
	int          mismatches = 0;
	int          frames_sent = 0;
	int          results_checked = 0;
	int          armed_results = 0;
	int          settings_applied = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void reset_model();
		for (int c = 0; c < 2; c++) begin
			nom_lim[c][0] = RST_NOMINAL_MIN;
			nom_lim[c][1] = RST_NOMINAL_MAX;
			cur_lim[c][0] = RST_NOMINAL_MIN;
			cur_lim[c][1] = RST_NOMINAL_MAX;
		end
		switch_on_thr = RST_SWITCH_THR;
		eps_frac = RST_EPSILON;
		for (int ch = 0; ch < 4; ch++) begin
			last_raw[ch] = '0;
			held_width[ch] = '0;
			chan_pos[ch] = 0;
			chan_goal[ch] = 1500;
		end
		link_seen = 1'b0;
		armed_seen = 1'b0;
	endfunction

	// writing a nominal limit reloads the live limit as well
	function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_STEER_MIN: begin
				nom_lim[0][0] = val[12:0];
				cur_lim[0][0] = val[12:0];
			end
			REG_STEER_MAX: begin
				nom_lim[0][1] = val[12:0];
				cur_lim[0][1] = val[12:0];
			end
			REG_THROTTLE_MIN: begin
				nom_lim[1][0] = val[12:0];
				cur_lim[1][0] = val[12:0];
			end
			REG_THROTTLE_MAX: begin
				nom_lim[1][1] = val[12:0];
				cur_lim[1][1] = val[12:0];
			end
			REG_SWITCH_THR: switch_on_thr = val[12:0];
			REG_EPSILON:    eps_frac = val[15:0];
			default: ;
		endcase
	endfunction

	function automatic cmd_t scale_to_q15(width_t v, width_t lo, width_t hi);
		longint num, den, dev, n, d, q, vv, lov, hiv, epsv;
		vv = v;
		lov = lo;
		hiv = hi;
		epsv = eps_frac;
		num = vv - lov;
		den = hiv - lov;
		if (den == 0)
			return '0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		dev = 2 * num - den;
		if (dev < 0)
			dev = -dev;
		if (dev * 65536 < epsv * den)
			return '0;
		n = 131072 * num + den;
		d = 2 * den;
		// floor division, rounds half up
		if (n >= 0)
			q = n / d;
		else
			q = -((-n + d - 1) / d);
		q = q - 32768;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return cmd_t'(q[15:0]);
	endfunction

	function automatic res_t condition_frame(frame_t f);
		width_t w [4];
		longint prev, cand, diff, epsv;
		int     v, lo, hi;
		res_t   r;
		w[0] = f.steer;
		w[1] = f.throttle;
		w[2] = f.arm;
		w[3] = f.calib;
		epsv = eps_frac;
		for (int ch = 0; ch < 4; ch++) begin
			if (w[ch] > WIDTH_TIMEOUT)
				w[ch] = '0;
			prev = last_raw[ch];
			cand = w[ch];
			diff = (prev > cand) ? prev - cand : cand - prev;
			if (!(diff * 65536 > epsv * prev))
				held_width[ch] = w[ch];
			last_raw[ch] = w[ch];
		end
		if (held_width[0] != 0 && held_width[1] != 0 && held_width[2] != 0)
			link_seen = 1'b1;
		if (link_seen)
			armed_seen = (held_width[2] >= switch_on_thr);
		if (link_seen && !armed_seen && held_width[3] >= switch_on_thr) begin
			for (int c = 0; c < 2; c++) begin
				v = held_width[c];
				lo = nom_lim[c][0];
				hi = nom_lim[c][1];
				if (4 * v < 3 * lo + hi && (v < cur_lim[c][0] || cur_lim[c][0] == nom_lim[c][0]))
					cur_lim[c][0] = held_width[c];
				if (4 * v > lo + 3 * hi && (v > cur_lim[c][1] || cur_lim[c][1] == nom_lim[c][1]))
					cur_lim[c][1] = held_width[c];
			end
		end
		r.link_up = link_seen;
		r.is_armed = armed_seen;
		if (link_seen && armed_seen) begin
			r.steer_cmd = scale_to_q15(held_width[0], cur_lim[0][0], cur_lim[0][1]);
			r.throttle_cmd = scale_to_q15(held_width[1], cur_lim[1][0], cur_lim[1][1]);
		end else begin
			r.steer_cmd = '0;
			r.throttle_cmd = '0;
		end
		return r;
	endfunction

	function automatic frame_t mk_frame(int s, int t, int a, int c);
		frame_t f;
		f.steer = width_t'(s);
		f.throttle = width_t'(t);
		f.arm = width_t'(a);
		f.calib = width_t'(c);
		return f;
	endfunction

	// mostly smooth stick and switch movement, plus timeouts, over-long pulses and glitches
	function automatic frame_t random_frame();
		int w [4];
		int r, lo, hi, span, step;
		for (int ch = 0; ch < 4; ch++) begin
			if ($urandom_range(0, 15) == 0) begin
				if (ch >= 2) begin
					if ($urandom_range(0, 5) == 0)
						chan_goal[ch] = $urandom_range(0, 5000);
					else
						chan_goal[ch] = $urandom_range(0, 1) ? 2000 : 1000;
				end else begin
					lo = (nom_lim[ch][0] < nom_lim[ch][1]) ? nom_lim[ch][0] : nom_lim[ch][1];
					hi = (nom_lim[ch][0] < nom_lim[ch][1]) ? nom_lim[ch][1] : nom_lim[ch][0];
					span = hi - lo;
					lo = lo - span / 4 - 50;
					hi = hi + span / 4 + 50;
					if (lo < 0)
						lo = 0;
					if (hi > 5000)
						hi = 5000;
					if ($urandom_range(0, 4) == 0)
						chan_goal[ch] = $urandom_range(0, 5000);
					else
						chan_goal[ch] = $urandom_range(lo, hi);
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				chan_pos[ch] = chan_goal[ch];
			end else begin
				// stay inside the glitch tolerance so moves get accepted
				step = (chan_pos[ch] * int'(eps_frac)) / 65536;
				step = $urandom_range(0, step);
				if (chan_goal[ch] > chan_pos[ch])
					chan_pos[ch] += (chan_goal[ch] - chan_pos[ch] < step) ?
						chan_goal[ch] - chan_pos[ch] : step;
				else
					chan_pos[ch] -= (chan_pos[ch] - chan_goal[ch] < step) ?
						chan_pos[ch] - chan_goal[ch] : step;
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				w[ch] = 0;
			else if (r < 5)
				w[ch] = $urandom_range(5001, 8191);
			else if (r < 8)
				w[ch] = $urandom_range(0, 8191);
			else
				w[ch] = chan_pos[ch];
		end
		return mk_frame(w[0], w[1], w[2], w[3]);
	endfunction

	function automatic void note_mismatch(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
	endfunction

	// entered and left at a falling edge
	task automatic send_frame(input frame_t f);
		int gap;
		if (send_calm > 0) begin
			send_calm--;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else if ($urandom_range(0, 39) == 0) begin
			send_calm = $urandom_range(10, 60);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, f};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(condition_frame(f));
		frames_sent++;
		@(negedge clk);
	endtask

	task automatic send_twice(int s, int t, int a, int c);
		send_frame(mk_frame(s, t, a, c));
		send_frame(mk_frame(s, t, a, c));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_check_read(logic [2:0] idx);
		logic [31:0] want;
		case (idx)
			REG_STEER_MIN:    want = {19'd0, nom_lim[0][0]};
			REG_STEER_MAX:    want = {19'd0, nom_lim[0][1]};
			REG_THROTTLE_MIN: want = {19'd0, nom_lim[1][0]};
			REG_THROTTLE_MAX: want = {19'd0, nom_lim[1][1]};
			REG_SWITCH_THR:   want = {19'd0, switch_on_thr};
			default:          want = {16'd0, eps_frac};
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			note_mismatch($sformatf("register %0d readback", idx), want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(int smin, int smax, int tmin, int tmax, int thr, int eps);
		apb_write(REG_STEER_MIN, smin);
		apb_write(REG_STEER_MAX, smax);
		apb_write(REG_THROTTLE_MIN, tmin);
		apb_write(REG_THROTTLE_MAX, tmax);
		apb_write(REG_SWITCH_THR, thr);
		apb_write(REG_EPSILON, eps);
		settings_applied++;
	endtask

	// no link until steer, throttle and arm are held nonzero; timeouts and over-long pulses
	task automatic test_link_and_timeout();
		send_frame(mk_frame(0, 0, 0, 0));
		send_twice(1500, 1500, 2000, 0);
		send_frame(mk_frame(8191, 1500, 2000, 0));
		send_twice(1500, 1500, 2000, 0);
		send_frame(mk_frame(4096, 5001, 2000, 0));
	endtask

	// each value twice: the first of a big jump is filtered out
	task automatic test_mapping();
		send_twice(1000, 2000, 2000, 0);
		send_twice(2000, 1000, 2000, 0);
		send_twice(1510, 1530, 2000, 0);
		send_twice(5000, 0, 2000, 0);
	endtask

	// widen limits while disarmed with calibrate on, then map with the new limits
	task automatic test_calibration();
		send_twice(900, 2100, 1000, 2000);
		send_twice(900, 2100, 2000, 2000);
	endtask

	task automatic test_registers();
		logic [31:0] junk;
		wait_idle();
		for (int i = 0; i < 6; i++) begin
			junk = $urandom;
			if (i == REG_EPSILON)
				apb_write(i[2:0], {junk[31:16], 16'($urandom_range(0, 65535))});
			else
				apb_write(i[2:0], {junk[31:13], 13'($urandom_range(0, 5000))});
			apb_check_read(i[2:0]);
		end
		// spare addresses decode to nothing
		apb_write(REG_SPARE_A, $urandom);
		apb_write(REG_SPARE_B, $urandom);
		settings_applied++;
		send_frame(mk_frame(1500, 1500, 2000, 0));
	endtask

	task automatic test_random_settings();
		int smin, smax, tmin, tmax, thr, eps;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			smin = 1000;
			smax = 2000;
			tmin = 1000;
			tmax = 2000;
			thr = 1500;
			eps = 3277;
			case (p)
				1: begin
					smin = 0;
					smax = 5000;
					tmin = 0;
					tmax = 5000;
					thr = 2500;
				end
				2: begin
					// reversed scale
					smin = 2000;
					smax = 1000;
					tmin = 2000;
					tmax = 1000;
					eps = 6000;
				end
				3: begin
					smin = 1500;
					smax = 1500;
					tmin = 1200;
					tmax = 1800;
				end
				4: thr = 0;
				5: thr = 5000;
				6: eps = 0;
				7: eps = 65535;
				8, 9: begin
					smin = $urandom_range(0, 5000);
					smax = $urandom_range(0, 5000);
					tmin = $urandom_range(0, 5000);
					tmax = $urandom_range(0, 5000);
					thr = $urandom_range(500, 2500);
					eps = $urandom_range(0, 16000);
				end
				default: ;
			endcase
			if (p == PHASE_COUNT - 1)
				idle_en = 1'b0;
			set_config(smin, smax, tmin, tmax, thr, eps);
			repeat (PHASE_ITEMS) send_frame(random_frame());
		end
	endtask

	initial begin
		int hold;
		int calm;
		hold = 0;
		calm = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (calm > 0) begin
				calm--;
				m_tready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				hold = $urandom_range(1, 19) - 1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					calm = $urandom_range(20, 100);
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing pending", 0, m_tdata[33:0]);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (m_tdata[1])
					armed_results++;
				if (m_tdata[0] !== want.link_up)
					note_mismatch("link_up", want.link_up, m_tdata[0]);
				if (m_tdata[1] !== want.is_armed)
					note_mismatch("is_armed", want.is_armed, m_tdata[1]);
				if (m_tdata[17:2] !== want.steer_cmd)
					note_mismatch("steer_cmd", want.steer_cmd, $signed(m_tdata[17:2]));
				if (m_tdata[33:18] !== want.throttle_cmd)
					note_mismatch("throttle_cmd", want.throttle_cmd, $signed(m_tdata[33:18]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("tb_rc_pulse_channel_conditioner NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		reset_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_link_and_timeout();
		test_mapping();
		test_calibration();
		test_registers();
		test_random_settings();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch("results never delivered", 0, pending_results.size());
		$display("%0d frames over %0d register settings, %0d results checked (%0d armed)",
			frames_sent, settings_applied, results_checked, armed_results);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("tb_rc_pulse_channel_conditioner OK");
		else
			$display("tb_rc_pulse_channel_conditioner NOT OK");
		$finish;
	end

endmodule
